FILE: design/depq_pkg.sv
// Shared types and codes for the double-ended priority queue.
// No dependencies.
package depq_pkg;

  localparam int unsigned OP_W = 2;
  localparam int unsigned ST_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP_MAX = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_MIN = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic start;
    logic step_id;
    logic step_pri;
    logic filt_en;
    logic filt_bit;
  } depq_ctl_t;

endpackage

FILE: design/double_ended_priority_queue.sv
// Top level of the double-ended priority queue: control sequencer and cell row.
// Depends on depq_pkg and depq_cell.
//
//  channel | direction | handshake                 | payload
//  request | in        | in_valid_i / in_ready_o   | opcode_i, entry_id_i, entry_priority_i
//  result  | out       | out_valid_o / out_ready_i | status_o, out_id_o, out_priority_o,
//          |           |                           | occupancy_o
//
// Insert matches the id one bit per cycle in every cell, then commits.
// Pops run the priority tournament, which eliminates one bit per cycle, then commit.
// A pop on an empty queue and an unused opcode skip the scan and go straight to commit.
// One request is in flight at a time; a finished result waits in the output register
// while the next request is accepted, and only the commit step stalls on it.
// Reset empties the queue at once; no clearing pass.
module double_ended_priority_queue import depq_pkg::*; #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ID_BITS       = 20,
  parameter int unsigned PRIORITY_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [OP_W-1:0]                  opcode_i,
  input  logic [ID_BITS-1:0]               entry_id_i,
  input  logic [PRIORITY_BITS-1:0]         entry_priority_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ST_W-1:0]                  status_o,
  output logic [ID_BITS-1:0]               out_id_o,
  output logic [PRIORITY_BITS-1:0]         out_priority_o,
  output logic [$clog2(CAPACITY+1)-1:0]    occupancy_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned MAXB   = (ID_BITS > PRIORITY_BITS) ? ID_BITS : PRIORITY_BITS;
  localparam int unsigned SCAN_W = $clog2(MAXB + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e                   state_q;
  logic [OP_W-1:0]          op_q;
  logic [ID_BITS-1:0]       id_sh_q;
  logic [PRIORITY_BITS-1:0] pri_in_q;
  logic [SCAN_W-1:0]        scan_q;
  logic [CNT_W-1:0]         count_q;
  logic                     out_valid_q;
  logic [ST_W-1:0]          status_q;
  logic [ID_BITS-1:0]       out_id_q;
  logic [PRIORITY_BITS-1:0] out_pri_q;
  logic [CNT_W-1:0]         occ_q;

  depq_ctl_t                ctl;
  logic                     in_fire;
  logic                     commit_go;
  logic                     do_ins, do_pop, ins_full, pop_empty;
  logic                     hit;
  logic [CNT_W-1:0]         count_rm;
  logic [CNT_W-1:0]         count_d;
  logic [ID_BITS-1:0]       sel_id;
  logic [PRIORITY_BITS-1:0] sel_pri;

  logic [CAPACITY-1:0]      flag, msb, below, live, take_next, load_new;
  logic [ID_BITS-1:0]       cell_id  [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_pri [CAPACITY];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit_go  = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl          = '0;
    ctl.start    = in_fire;
    ctl.step_id  = (state_q == S_SCAN) && (op_q == OP_INSERT);
    ctl.step_pri = (state_q == S_SCAN) && (op_q != OP_INSERT);
    ctl.filt_bit = (op_q == OP_POP_MAX);
    ctl.filt_en  = (op_q == OP_POP_MAX) ? |(flag & msb) : |(flag & ~msb);
  end

  always_comb begin
    hit   = |flag;
    below = ~((flag - CAPACITY'(1)) & ~flag);
  end

  always_comb begin
    sel_id  = '0;
    sel_pri = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (flag[k] && (k == 0 || !below[(k == 0) ? 0 : k-1])) begin
        sel_id  = sel_id | cell_id[k];
        sel_pri = sel_pri | cell_pri[k];
      end
    end
  end

  always_comb begin
    do_ins    = 1'b0;
    do_pop    = 1'b0;
    ins_full  = 1'b0;
    pop_empty = 1'b0;
    count_rm  = count_q - CNT_W'(hit);
    count_d   = count_q;
    unique case (op_q)
      OP_INSERT: begin
        if (!hit && (count_q == CNT_W'(CAPACITY))) begin
          ins_full = 1'b1;
        end else begin
          do_ins  = 1'b1;
          count_d = count_rm + CNT_W'(1);
        end
      end
      OP_POP_MAX, OP_POP_MIN: begin
        if (count_q == '0) begin
          pop_empty = 1'b1;
        end else begin
          do_pop  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      live[k]      = (CNT_W'(k) < count_q);
      take_next[k] = commit_go && (do_ins || do_pop) && below[k];
      load_new[k]  = commit_go && do_ins && (CNT_W'(k) == count_rm);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    depq_cell #(
      .ID_BITS      (ID_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .live_i     (live[g]),
      .id_bit_i   (id_sh_q[0]),
      .take_next_i(take_next[g]),
      .load_new_i (load_new[g]),
      .next_id_i  (cell_id[(g + 1 < CAPACITY) ? g + 1 : g]),
      .next_pri_i (cell_pri[(g + 1 < CAPACITY) ? g + 1 : g]),
      .new_id_i   (id_sh_q),
      .new_pri_i  (pri_in_q),
      .id_o       (cell_id[g]),
      .pri_o      (cell_pri[g]),
      .flag_o     (flag[g]),
      .msb_o      (msb[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INSERT;
      id_sh_q     <= '0;
      pri_in_q    <= '0;
      scan_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      out_id_q    <= '0;
      out_pri_q   <= '0;
      occ_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q     <= opcode_i;
            id_sh_q  <= entry_id_i;
            pri_in_q <= entry_priority_i;
            if (opcode_i == OP_INSERT) begin
              scan_q  <= SCAN_W'(ID_BITS);
              state_q <= S_SCAN;
            end else if ((opcode_i == OP_POP_MAX || opcode_i == OP_POP_MIN)
                         && count_q != '0) begin
              scan_q  <= SCAN_W'(PRIORITY_BITS);
              state_q <= S_SCAN;
            end else begin
              state_q <= S_COMMIT;
            end
          end
        end
        S_SCAN: begin
          if (op_q == OP_INSERT) begin
            id_sh_q <= {id_sh_q[0], id_sh_q[ID_BITS-1:1]};
          end
          scan_q <= scan_q - SCAN_W'(1);
          if (scan_q == SCAN_W'(1)) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_go) begin
            out_valid_q <= 1'b1;
            count_q     <= count_d;
            occ_q       <= count_d;
            out_id_q    <= do_pop ? sel_id : '0;
            out_pri_q   <= do_pop ? sel_pri : '0;
            if (ins_full) begin
              status_q <= ST_FULL;
            end else if (pop_empty) begin
              status_q <= ST_EMPTY;
            end else begin
              status_q <= ST_OK;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_pri_q;
  assign occupancy_o    = occ_q;

endmodule

FILE: design/depq_cell.sv
// One storage cell of the queue: bit-serial id match and priority tournament.
// Depends on depq_pkg.
module depq_cell import depq_pkg::*; #(
  parameter int unsigned ID_BITS       = 20,
  parameter int unsigned PRIORITY_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  depq_ctl_t                ctl_i,
  input  logic                     live_i,
  input  logic                     id_bit_i,
  input  logic                     take_next_i,
  input  logic                     load_new_i,
  input  logic [ID_BITS-1:0]       next_id_i,
  input  logic [PRIORITY_BITS-1:0] next_pri_i,
  input  logic [ID_BITS-1:0]       new_id_i,
  input  logic [PRIORITY_BITS-1:0] new_pri_i,
  output logic [ID_BITS-1:0]       id_o,
  output logic [PRIORITY_BITS-1:0] pri_o,
  output logic                     flag_o,
  output logic                     msb_o
);

  logic [ID_BITS-1:0]       id_q;
  logic [PRIORITY_BITS-1:0] pri_q;
  logic                     flag_q, flag_d;

  always_comb begin
    flag_d = flag_q;
    if (ctl_i.start) begin
      flag_d = live_i;
    end else if (ctl_i.step_id) begin
      flag_d = flag_q & (id_q[0] == id_bit_i);
    end else if (ctl_i.step_pri) begin
      flag_d = flag_q & (!ctl_i.filt_en || (pri_q[PRIORITY_BITS-1] == ctl_i.filt_bit));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_new_i) begin
      id_q  <= new_id_i;
      pri_q <= new_pri_i;
    end else if (take_next_i) begin
      id_q  <= next_id_i;
      pri_q <= next_pri_i;
    end else begin
      if (ctl_i.step_id) begin
        id_q <= {id_q[0], id_q[ID_BITS-1:1]};
      end
      if (ctl_i.step_pri) begin
        pri_q <= {pri_q[PRIORITY_BITS-2:0], pri_q[PRIORITY_BITS-1]};
      end
    end
  end

  assign id_o   = id_q;
  assign pri_o  = pri_q;
  assign flag_o = flag_q;
  assign msb_o  = pri_q[PRIORITY_BITS-1];

endmodule

FILE: design/depq_checker.sv
// Port-level checks for the double-ended priority queue, bound to the top level.
// Depends on depq_pkg and double_ended_priority_queue.
module depq_checker import depq_pkg::*; #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ID_BITS       = 20,
  parameter int unsigned PRIORITY_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ST_W-1:0]               status_o,
  input logic [ID_BITS-1:0]            out_id_o,
  input logic [PRIORITY_BITS-1:0]      out_priority_o,
  input logic [$clog2(CAPACITY+1)-1:0] occupancy_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupancy_o <= CNT_W'(CAPACITY)))
    else $error("occupancy above capacity");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |->
      (occupancy_o == CNT_W'(CAPACITY) && out_id_o == '0 && out_priority_o == '0))
    else $error("full status with room left or nonzero payload");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |->
      (occupancy_o == '0 && out_id_o == '0 && out_priority_o == '0))
    else $error("empty status with live entries or nonzero payload");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(out_id_o) && $stable(out_priority_o)
       && $stable(occupancy_o)))
    else $error("stalled result changed");

endmodule

bind double_ended_priority_queue depq_checker #(
  .CAPACITY     (CAPACITY),
  .ID_BITS      (ID_BITS),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_depq_checker (.*);
